// ===== hw/rtl/bls_pkg.sv =====
// Shared types and constants for the Bresenham line stepper.
package bls_pkg;

    localparam int COORD_BITS  = 12;
    localparam int DEC_W       = COORD_BITS + 2;
    localparam int STR_W       = COORD_BITS + 1;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic ACTION_START = 1'b0;
    localparam logic ACTION_STEP  = 1'b1;

    typedef logic [COORD_BITS-1:0]   coord_t;
    typedef logic signed [DEC_W-1:0] dec_t;
    typedef logic [STR_W-1:0]        str_inc_t;

    // One classified command as it travels from the front end to the walker.
    typedef struct packed {
        logic     is_start;
        coord_t   pos_x;
        coord_t   pos_y;
        coord_t   major_limit;
        dec_t     decision;
        str_inc_t straight_inc;
        dec_t     diagonal_inc;
        logic     major_is_x;
        logic     minor_inc;
    } line_cmd_t;

endpackage

// ===== hw/rtl/bresenham_line_stepper.sv =====
// Top level of the Bresenham line stepper: front end, command queue and line walker.
//
// Usage: the input channel (in_valid/in_ready) carries one command per transfer.
// With action at start, the two endpoints are taken and the first pixel of the
// new line is produced; with action at step, the next pixel of the current line
// is produced, and last_pixel marks the line's final pixel. A step transfer
// while no line is in progress produces nothing. A start during a line drops it.
// The output channel (out_valid/out_ready) carries one pixel per transfer.
// An accepted command is written into the command queue, and the walker then
// registers its pixel in the output register. Throughput: one command and one pixel
// per cycle while out_ready is high, set by the walker's one add and compare per pixel.
// A two-entry command queue sits between the front end and the walker, so while
// the receiver stalls, up to two further commands are still accepted before
// in_ready falls; a stalled pixel is held unchanged in the output register.
// Reset (rst_n low, asynchronous) empties the queue, clears the output valid flag
// and leaves the stepper idle with no line in progress.
module bresenham_line_stepper
    import bls_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   in_valid,
    output logic   in_ready,
    input  logic   action,
    input  coord_t start_x,
    input  coord_t start_y,
    input  coord_t end_x,
    input  coord_t end_y,
    output logic   out_valid,
    input  logic   out_ready,
    output coord_t pixel_x,
    output coord_t pixel_y,
    output logic   last_pixel
);

    line_cmd_t front_cmd;
    line_cmd_t queue_cmd;
    logic      queue_full;
    logic      queue_valid;
    logic      queue_pop;

    // The front end is pure decode; its result is written straight into the queue.
    bls_front u_front (
        .action  (action),
        .start_x (start_x),
        .start_y (start_y),
        .end_x   (end_x),
        .end_y   (end_y),
        .cmd     (front_cmd)
    );

    // A command is accepted whenever the queue has room, independent of the output side.
    assign in_ready = !queue_full;

    bls_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (in_valid),
        .push_data (front_cmd),
        .full      (queue_full),
        .pop       (queue_pop),
        .pop_valid (queue_valid),
        .pop_data  (queue_cmd)
    );

    // The walker consumes a command whenever its output register is free or being emptied.
    bls_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_valid  (queue_valid),
        .cmd        (queue_cmd),
        .cmd_pop    (queue_pop),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .pixel_x    (pixel_x),
        .pixel_y    (pixel_y),
        .last_pixel (last_pixel)
    );

endmodule

// ===== hw/rtl/bls_front.sv =====
// Front end: classifies an input item and works out the line set-up for a start.
module bls_front
    import bls_pkg::*;
(
    input  logic      action,
    input  coord_t    start_x,
    input  coord_t    start_y,
    input  coord_t    end_x,
    input  coord_t    end_y,
    output line_cmd_t cmd
);

    logic   swap;
    logic   y_up;
    logic   major_x;
    coord_t x0;
    coord_t y0;
    coord_t x1;
    coord_t y1;
    coord_t dx;
    coord_t dy;
    coord_t mj;
    coord_t mn;

    always_comb
    begin
        // Order the endpoints so that x never decreases from first to second.
        swap    = (end_x < start_x);
        x0      = swap ? end_x   : start_x;
        y0      = swap ? end_y   : start_y;
        x1      = swap ? start_x : end_x;
        y1      = swap ? start_y : end_y;
        y_up    = (y1 >= y0);
        dx      = x1 - x0;
        dy      = y_up ? (y1 - y0) : (y0 - y1);
        major_x = (dx >= dy);
        mj      = major_x ? dx : dy;
        mn      = major_x ? dy : dx;

        cmd.is_start   = (action == ACTION_START);
        cmd.major_is_x = major_x;
        cmd.minor_inc  = y_up;

        if (major_x || y_up)
        begin
            cmd.pos_x       = x0;
            cmd.pos_y       = y0;
            cmd.major_limit = major_x ? x1 : y1;
        end
        else
        begin
            // A steep descending line is walked upwards from its lower end.
            cmd.pos_x       = x1;
            cmd.pos_y       = y1;
            cmd.major_limit = y0;
        end

        cmd.decision     = $signed({1'b0, mn, 1'b0}) - $signed({2'b00, mj});
        cmd.straight_inc = {mn, 1'b0};
        cmd.diagonal_inc = $signed({1'b0, mn, 1'b0}) - $signed({1'b0, mj, 1'b0});
    end

endmodule

// ===== hw/rtl/bls_queue.sv =====
// Short command queue between the front end and the line walker.
module bls_queue
    import bls_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  line_cmd_t push_data,
    output logic      full,
    input  logic      pop,
    output logic      pop_valid,
    output line_cmd_t pop_data
);

    line_cmd_t          entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg;
    logic [QPTR_W-1:0]  wr_ptr_next;
    logic [QPTR_W-1:0]  rd_ptr_reg;
    logic [QPTR_W-1:0]  rd_ptr_next;
    logic [QCNT_W-1:0]  count_reg;
    logic [QCNT_W-1:0]  count_next;
    logic               push_ok;
    logic               pop_ok;

    assign full      = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign pop_valid = (count_reg != '0);
    assign pop_data  = entry_reg[rd_ptr_reg];
    assign push_ok   = push && !full;
    assign pop_ok    = pop && pop_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push_ok)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop_ok)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({push_ok, pop_ok})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_ok)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== hw/rtl/bls_back.sv =====
// Line walker: holds the line state, loads or steps it and registers the pixel.
module bls_back
    import bls_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      cmd_valid,
    input  line_cmd_t cmd,
    output logic      cmd_pop,
    output logic      out_valid,
    input  logic      out_ready,
    output coord_t    pixel_x,
    output coord_t    pixel_y,
    output logic      last_pixel
);

    logic     active_reg;
    logic     active_next;
    coord_t   pos_x_reg;
    coord_t   pos_y_reg;
    coord_t   limit_reg;
    dec_t     dec_reg;
    str_inc_t str_reg;
    dec_t     diag_reg;
    logic     major_x_reg;
    logic     minor_inc_reg;
    logic     out_valid_reg;
    logic     out_valid_next;
    coord_t   pixel_x_reg;
    coord_t   pixel_y_reg;
    logic     last_reg;

    logic     load;
    logic     advance;
    logic     emit;
    logic     straight;
    dec_t     step_dec;
    coord_t   minor_src;
    coord_t   minor_moved;
    coord_t   step_x;
    coord_t   step_y;
    coord_t   pos_x_next;
    coord_t   pos_y_next;
    coord_t   limit_next;
    dec_t     dec_next;
    str_inc_t str_next;
    dec_t     diag_next;
    logic     major_x_next;
    logic     minor_inc_next;
    logic     last;

    assign cmd_pop = cmd_valid && (!out_valid_reg || out_ready);
    assign load    = cmd_pop && cmd.is_start;
    assign advance = cmd_pop && !cmd.is_start && active_reg;
    assign emit    = load || advance;

    always_comb
    begin
        straight    = dec_reg[DEC_W-1] || (dec_reg == '0);
        step_dec    = dec_reg + (straight ? dec_t'({1'b0, str_reg}) : diag_reg);
        minor_src   = major_x_reg ? pos_y_reg : pos_x_reg;
        minor_moved = minor_inc_reg ? minor_src + 1'b1 : minor_src - 1'b1;
        step_x      = major_x_reg ? pos_x_reg + 1'b1 : (straight ? pos_x_reg : minor_moved);
        step_y      = major_x_reg ? (straight ? pos_y_reg : minor_moved) : pos_y_reg + 1'b1;

        pos_x_next     = pos_x_reg;
        pos_y_next     = pos_y_reg;
        limit_next     = limit_reg;
        dec_next       = dec_reg;
        str_next       = str_reg;
        diag_next      = diag_reg;
        major_x_next   = major_x_reg;
        minor_inc_next = minor_inc_reg;
        if (load)
        begin
            pos_x_next     = cmd.pos_x;
            pos_y_next     = cmd.pos_y;
            limit_next     = cmd.major_limit;
            dec_next       = cmd.decision;
            str_next       = cmd.straight_inc;
            diag_next      = cmd.diagonal_inc;
            major_x_next   = cmd.major_is_x;
            minor_inc_next = cmd.minor_inc;
        end
        else if (advance)
        begin
            pos_x_next = step_x;
            pos_y_next = step_y;
            dec_next   = step_dec;
        end

        last        = ((major_x_next ? pos_x_next : pos_y_next) == limit_next);
        active_next = emit ? !last : active_reg;

        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else
        begin
            out_valid_next = out_ready ? 1'b0 : out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            active_reg    <= active_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_x_reg     <= pos_x_next;
        pos_y_reg     <= pos_y_next;
        limit_reg     <= limit_next;
        dec_reg       <= dec_next;
        str_reg       <= str_next;
        diag_reg      <= diag_next;
        major_x_reg   <= major_x_next;
        minor_inc_reg <= minor_inc_next;
        if (emit)
        begin
            pixel_x_reg <= pos_x_next;
            pixel_y_reg <= pos_y_next;
            last_reg    <= last;
        end
    end

    assign out_valid  = out_valid_reg;
    assign pixel_x    = pixel_x_reg;
    assign pixel_y    = pixel_y_reg;
    assign last_pixel = last_reg;

endmodule

// ===== hw/rtl/bls_checker.sv =====
// Port-level checker for the Bresenham line stepper, with its bind statement.
module bls_checker
    import bls_pkg::*;
(
    input logic   clk,
    input logic   rst_n,
    input logic   in_ready,
    input logic   out_valid,
    input logic   out_ready,
    input coord_t pixel_x,
    input coord_t pixel_y,
    input logic   last_pixel
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("output valid dropped before transfer");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(pixel_x) && $stable(pixel_y) && $stable(last_pixel))
        else $error("stalled pixel changed");

    // The queue can only fill up behind a stalled output register.
    a_full_needs_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid)
        else $error("input blocked with no pixel waiting");

    a_full_stays: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready && !out_ready |=> !in_ready)
        else $error("queue drained while output stalled");

endmodule

bind bresenham_line_stepper bls_checker u_bls_checker (.*);

// ===== tb/bresenham_line_stepper_tb.sv =====
// Self-checking testbench for the Bresenham line stepper: directed lines, back-pressure and random walks.
module bresenham_line_stepper_tb;
    import bls_pkg::*;

    // A transfer that sees no activity on either channel for this many cycles
    // means the block has hung. The longest correct quiet spell is the forced
    // output stall plus a run of random idles, far below this figure.
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int STALL_CYCLES   = 60;
    localparam int IDLE_PERCENT   = 29;
    localparam int COORD_MAX      = (1 << COORD_BITS) - 1;

    // One expected pixel as it should leave the output channel.
    typedef struct packed {
        coord_t x;
        coord_t y;
        logic   last;
    } pixel_t;

    // Every input starts at a known value; reset is held low from time zero.
    logic   clk        = 1'b0;
    logic   rst_n      = 1'b0;
    logic   in_valid   = 1'b0;
    logic   action     = ACTION_START;
    coord_t start_x    = '0;
    coord_t start_y    = '0;
    coord_t end_x      = '0;
    coord_t end_y      = '0;
    logic   out_ready  = 1'b0;
    logic   in_ready;
    logic   out_valid;
    coord_t pixel_x;
    coord_t pixel_y;
    logic   last_pixel;

    // Pixels predicted but not yet seen on the output, oldest first.
    pixel_t pending_pixels[$];

    // The predictor's own copy of the walker state.
    logic   line_active;
    coord_t cur_x;
    coord_t cur_y;
    coord_t major_end;
    int     decision_val;
    int     straight_step;
    int     diagonal_step;
    logic   x_is_major;
    logic   minor_goes_up;

    // When set, neither side inserts random idle cycles.
    bit no_idle       = 1'b0;
    // Raised by a test to ask the pixel sink for one long hold-off.
    bit stall_request = 1'b0;

    int mismatch_count  = 0;
    int starts_sent     = 0;
    int steps_sent      = 0;
    int idle_steps_sent = 0;
    int pixels_checked  = 0;

    bresenham_line_stepper DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .action     (action),
        .start_x    (start_x),
        .start_y    (start_y),
        .end_x      (end_x),
        .end_y      (end_y),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .pixel_x    (pixel_x),
        .pixel_y    (pixel_y),
        .last_pixel (last_pixel)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        $display("MISMATCH: %s", msg);
    endtask

    // Works out what one accepted command does to the walker and queues the
    // pixel that it produces, if any. A start swaps the endpoints when the end
    // lies to the left, picks the major axis, and for steep descending lines
    // begins at the lower endpoint so that the major coordinate always rises.
    task automatic rasterise_command(input logic act, input coord_t sx, input coord_t sy,
                                     input coord_t ex, input coord_t ey);
        int     x0;
        int     y0;
        int     x1;
        int     y1;
        int     swap_tmp;
        int     dx;
        int     dy;
        int     major_len;
        int     minor_len;
        pixel_t px;
        if (act == ACTION_START)
        begin
            x0 = int'(sx);
            y0 = int'(sy);
            x1 = int'(ex);
            y1 = int'(ey);
            if (x1 < x0)
            begin
                swap_tmp = x0; x0 = x1; x1 = swap_tmp;
                swap_tmp = y0; y0 = y1; y1 = swap_tmp;
            end
            dx = x1 - x0;
            dy = (y1 >= y0) ? (y1 - y0) : (y0 - y1);
            x_is_major = (dx >= dy);
            if (x_is_major)
            begin
                major_len     = dx;
                minor_len     = dy;
                cur_x         = coord_t'(x0);
                cur_y         = coord_t'(y0);
                major_end     = coord_t'(x1);
                minor_goes_up = (y1 >= y0);
            end
            else if (y1 >= y0)
            begin
                major_len     = dy;
                minor_len     = dx;
                cur_x         = coord_t'(x0);
                cur_y         = coord_t'(y0);
                major_end     = coord_t'(y1);
                minor_goes_up = 1'b1;
            end
            else
            begin
                major_len     = dy;
                minor_len     = dx;
                cur_x         = coord_t'(x1);
                cur_y         = coord_t'(y1);
                major_end     = coord_t'(y0);
                minor_goes_up = 1'b0;
            end
            decision_val  = 2 * minor_len - major_len;
            straight_step = 2 * minor_len;
            diagonal_step = 2 * (minor_len - major_len);
        end
        else
        begin
            // A step with no line in progress is simply swallowed.
            if (!line_active)
                return;
            if (decision_val <= 0)
                decision_val += straight_step;
            else
            begin
                decision_val += diagonal_step;
                if (x_is_major)
                    cur_y = minor_goes_up ? cur_y + 1'b1 : cur_y - 1'b1;
                else
                    cur_x = minor_goes_up ? cur_x + 1'b1 : cur_x - 1'b1;
            end
            if (x_is_major)
                cur_x = cur_x + 1'b1;
            else
                cur_y = cur_y + 1'b1;
        end
        px.x        = cur_x;
        px.y        = cur_y;
        px.last     = ((x_is_major ? cur_x : cur_y) == major_end);
        line_active = !px.last;
        pending_pixels.push_back(px);
    endtask

    // Offers one command on the input channel and returns at the clock edge
    // where it is transferred. It must be called just after a rising edge.
    // Random idle cycles are inserted ahead of the command; once valid is up
    // it stays up with the payload frozen until in_ready is seen.
    task automatic send_command(input logic act, input coord_t sx, input coord_t sy,
                                input coord_t ex, input coord_t ey);
        while (!no_idle && $urandom_range(0, 99) < IDLE_PERCENT)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        action   <= act;
        start_x  <= sx;
        start_y  <= sy;
        end_x    <= ex;
        end_y    <= ey;
        do
            @(posedge clk);
        while (!in_ready);
        if (act == ACTION_START)
            starts_sent++;
        else if (line_active)
            steps_sent++;
        else
            idle_steps_sent++;
        rasterise_command(act, sx, sy, ex, ey);
    endtask

    function automatic coord_t any_coord();
        return coord_t'($urandom_range(0, COORD_MAX));
    endfunction

    // A coordinate within span of the given one, clamped to the screen.
    function automatic coord_t near_coord(input coord_t c, input int span);
        int v;
        v = int'(c) + int'($urandom_range(0, 2 * span)) - span;
        if (v < 0)
            v = 0;
        if (v > COORD_MAX)
            v = COORD_MAX;
        return coord_t'(v);
    endfunction

    function automatic coord_t edgy_coord();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return coord_t'(COORD_MAX);
            default: return any_coord();
        endcase
    endfunction

    task automatic send_start(input coord_t sx, input coord_t sy, input coord_t ex,
                              input coord_t ey);
        send_command(ACTION_START, sx, sy, ex, ey);
    endtask

    // Step transfers carry random endpoint fields, which the block must ignore.
    task automatic send_step();
        send_command(ACTION_STEP, any_coord(), any_coord(), any_coord(), any_coord());
    endtask

    task automatic walk_line(input int max_steps);
        int n;
        n = 0;
        while (line_active && n < max_steps)
        begin
            send_step();
            n++;
        end
    endtask

    // One well-formed line with random content. Most lines are short and walked
    // to the end; some are cut off by the next start, a few are long, and now
    // and then stray steps follow the final pixel.
    task automatic random_line();
        coord_t x0;
        coord_t y0;
        int     span;
        int     cut;
        span = ($urandom_range(0, 19) == 0) ? 100 : 12;
        x0   = edgy_coord();
        y0   = edgy_coord();
        if ($urandom_range(0, 9) == 0)
            send_start(x0, y0, any_coord(), any_coord());
        else
            send_start(x0, y0, near_coord(x0, span), near_coord(y0, span));
        cut = ($urandom_range(0, 7) == 0) ? int'($urandom_range(0, 6)) : 64;
        walk_line(cut);
        if (!line_active && $urandom_range(0, 5) == 0)
            repeat ($urandom_range(1, 2)) send_step();
    endtask

    task automatic random_lines_for(input int item_budget);
        int first;
        first = starts_sent + steps_sent;
        while (starts_sent + steps_sent - first < item_budget)
            random_line();
    endtask

    task automatic test_step_while_idle();
        send_step();
    endtask

    task automatic test_single_point();
        send_start('0, '0, '0, '0);
        send_start(coord_t'(COORD_MAX), coord_t'(COORD_MAX), coord_t'(COORD_MAX),
                   coord_t'(COORD_MAX));
        send_step();
    endtask

    // Short lines in the octant classes: shallow rising, shallow falling after
    // a swap, steep falling (walked from the lower end with x going down) and
    // steep rising, followed by a step after the line has finished.
    task automatic test_octants();
        send_start(12'd10, 12'd10, 12'd12, 12'd11);
        walk_line(8);
        send_start(12'd22, 12'd20, 12'd20, 12'd21);
        walk_line(8);
        send_start(12'd30, 12'd32, 12'd31, 12'd30);
        walk_line(8);
        send_start(12'd40, 12'd40, 12'd41, 12'd42);
        walk_line(8);
        send_step();
    endtask

    // Full-width horizontal, vertical and diagonal lines at the screen edges,
    // each abandoned after one step by the next start.
    task automatic test_extremes();
        send_start('0, '0, coord_t'(COORD_MAX), '0);
        send_step();
        send_start('0, coord_t'(COORD_MAX), '0, '0);
        send_step();
        send_start(coord_t'(COORD_MAX), coord_t'(COORD_MAX), '0, '0);
        send_step();
        send_start('0, coord_t'(COORD_MAX), coord_t'(COORD_MAX), '0);
        send_step();
    endtask

    // The sink holds off for a long spell while a line is streamed without
    // gaps, so the command queue fills and in_ready has to fall.
    task automatic test_backpressure();
        no_idle       = 1'b1;
        stall_request = 1'b1;
        send_start(12'd100, 12'd200, 12'd140, 12'd210);
        walk_line(1 << 30);
        no_idle = 1'b0;
    endtask

    task automatic test_steady_stream();
        no_idle = 1'b1;
        random_lines_for(60);
        no_idle = 1'b0;
    endtask

    task automatic test_random_lines();
        random_lines_for(260);
    endtask

    // Pixel sink: checks every output transfer against the oldest prediction
    // and chooses out_ready for the next cycle.
    initial
    begin : pixel_sink
        int     stall_left;
        pixel_t want;
        stall_left = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && out_ready)
            begin
                if (pending_pixels.size() == 0)
                    report_mismatch($sformatf("unexpected pixel (%0d,%0d) last=%0b",
                                              pixel_x, pixel_y, last_pixel));
                else
                begin
                    want = pending_pixels.pop_front();
                    if (pixel_x !== want.x)
                        report_mismatch($sformatf("pixel %0d: pixel_x %0d, expected %0d",
                                                  pixels_checked, pixel_x, want.x));
                    if (pixel_y !== want.y)
                        report_mismatch($sformatf("pixel %0d: pixel_y %0d, expected %0d",
                                                  pixels_checked, pixel_y, want.y));
                    if (last_pixel !== want.last)
                        report_mismatch($sformatf("pixel %0d: last_pixel %0b, expected %0b",
                                                  pixels_checked, last_pixel, want.last));
                    pixels_checked++;
                end
            end
            if (stall_request)
            begin
                stall_left    = STALL_CYCLES;
                stall_request = 1'b0;
            end
            if (stall_left > 0)
            begin
                stall_left--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= no_idle || ($urandom_range(0, 99) >= IDLE_PERCENT);
        end
    end

    // Watchdog: ends the run if neither channel completes a transfer for too long.
    initial
    begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("Watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
        $display("Mismatches found");
        $finish;
    end

    // Main sequence: reset once, run the tests in turn, then drain.
    initial
    begin
        line_active   = 1'b0;
        cur_x         = '0;
        cur_y         = '0;
        major_end     = '0;
        decision_val  = 0;
        straight_step = 0;
        diagonal_step = 0;
        x_is_major    = 1'b0;
        minor_goes_up = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_step_while_idle();
        test_single_point();
        test_octants();
        test_extremes();
        test_backpressure();
        test_steady_stream();
        test_random_lines();
        in_valid <= 1'b0;

        // Let the last pixels out, then allow a few more cycles so that a
        // stray extra pixel would still be caught.
        while (pending_pixels.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        $display("Run covered %0d line starts, %0d line steps and %0d steps while idle.",
                 starts_sent, steps_sent, idle_steps_sent);
        $display("%0d pixels checked, with restarts mid-line and a long output stall.",
                 pixels_checked);
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
